### rtl/lstok_pkg.sv
// Package for the Lisp source tokenizer: token result and push types,
// lexer mode codes, character constants and byte classification helpers.
// No dependencies.
package lstok_pkg;

   // Default depth of the result queue (needs at least two entries)
   localparam int unsigned QUEUE_DEPTH = 4;

   // Character codes the lexer reacts to
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] FOLD_OFFSET  = 8'd32;

   // Request kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // End codes on the end-of-input result
   localparam logic [1:0] END_NONE   = 2'd0;
   localparam logic [1:0] END_NORMAL = 2'd1;
   localparam logic [1:0] END_BROKEN = 2'd2;

   // Lexer modes
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_ATOM     = 3'd1,
      MODE_ATOM_ESC = 3'd2,
      MODE_STR      = 3'd3,
      MODE_STR_ESC  = 3'd4,
      MODE_COMMENT  = 3'd5
   } lex_mode_type;

   // One result item
   typedef struct packed {
      logic [7:0] tok_byte;
      logic       tok_valid;
      logic       tok_last;
      logic [1:0] end_status;
   } tok_result_type;

   // Results of one request, handed from the lexer core to the queue
   typedef struct packed {
      logic           push_first;
      logic           push_second;
      tok_result_type first;
      tok_result_type second;
   } tok_push_type;

   // Whitespace: newline, return, tab, form feed, vertical tab, space
   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h0A, 8'h0D, 8'h09, 8'h0C, 8'h0B, 8'h20};
   endfunction

   // Delimiters: whitespace, parentheses, quote, semicolon, quote marks, comma
   function automatic logic is_delim(input logic [7:0] c);
      return is_space(c) || (c inside {8'h28, 8'h29, 8'h22, 8'h3B, 8'h27, 8'h60, 8'h2C});
   endfunction

   // Fold upper-case ASCII letters to lower case
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + FOLD_OFFSET;
      end
      return r;
   endfunction

endpackage

### rtl/lstok_lexer_core.sv
// Lexer core: mode register and held atom byte, produces up to two
// results per accepted request. Depends on lstok_pkg.
module lstok_lexer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 req_kind,
   input  logic [7:0]           req_byte,
   output lstok_pkg::tok_push_type push
);
   import lstok_pkg::*;

   lex_mode_type mode_ff, mode_in;
   logic [7:0]   held_byte_ff, held_byte_in;
   logic         held_valid_ff, held_valid_in;

   // Classification of a byte seen between tokens
   logic           bt_emit;
   tok_result_type bt_res;
   lex_mode_type   bt_mode;
   logic           bt_hold;
   logic           c_delim;

   assign c_delim = is_delim(req_byte);

   always_comb begin
      bt_emit           = 1'b0;
      bt_hold           = 1'b0;
      bt_mode           = MODE_IDLE;
      bt_res.tok_byte   = req_byte;
      bt_res.tok_valid  = 1'b1;
      bt_res.tok_last   = 1'b1;
      bt_res.end_status = END_NONE;
      if (req_byte == CHAR_QUOTE) begin
         bt_emit         = 1'b1;
         bt_res.tok_last = 1'b0;
         bt_mode         = MODE_STR;
      end else if (req_byte == CHAR_SEMI) begin
         bt_mode = MODE_COMMENT;
      end else if (is_space(req_byte)) begin
         bt_mode = MODE_IDLE;
      end else if (c_delim) begin
         bt_emit = 1'b1;
      end else begin
         bt_hold = 1'b1;
         bt_mode = (req_byte == CHAR_BSLASH) ? MODE_ATOM_ESC : MODE_ATOM;
      end
   end

   // Next state
   always_comb begin
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (req_kind == KIND_END) begin
         mode_in       = MODE_IDLE;
         held_byte_in  = '0;
         held_valid_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_ATOM: begin
               if (c_delim) begin
                  held_byte_in  = '0;
                  held_valid_in = 1'b0;
                  mode_in       = bt_mode;
               end else begin
                  held_byte_in  = fold(req_byte);
                  held_valid_in = 1'b1;
                  mode_in = (req_byte == CHAR_BSLASH) ? MODE_ATOM_ESC : MODE_ATOM;
               end
            end
            MODE_ATOM_ESC: begin
               held_byte_in  = fold(req_byte);
               held_valid_in = 1'b1;
               mode_in       = MODE_ATOM;
            end
            MODE_STR: begin
               if (req_byte == CHAR_BSLASH) begin
                  mode_in = MODE_STR_ESC;
               end else if (req_byte == CHAR_QUOTE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STR_ESC: begin
               mode_in = MODE_STR;
            end
            MODE_COMMENT: begin
               if (req_byte == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = bt_mode;
               if (bt_hold) begin
                  held_byte_in  = fold(req_byte);
                  held_valid_in = 1'b1;
               end
            end
         endcase
      end
   end

   // Results
   always_comb begin
      push.push_first        = 1'b0;
      push.push_second       = 1'b0;
      push.first.tok_byte    = held_byte_ff;
      push.first.tok_valid   = 1'b1;
      push.first.tok_last    = 1'b0;
      push.first.end_status  = END_NONE;
      push.second            = bt_res;
      if (req_kind == KIND_END) begin
         push.push_first       = req_accept;
         push.first.tok_byte   = held_valid_ff ? held_byte_ff : 8'd0;
         push.first.tok_valid  = held_valid_ff;
         push.first.tok_last   = held_valid_ff;
         push.first.end_status = (mode_ff == MODE_ATOM_ESC || mode_ff == MODE_STR ||
                                  mode_ff == MODE_STR_ESC) ? END_BROKEN : END_NORMAL;
      end else begin
         case (mode_ff)
            MODE_ATOM: begin
               push.push_first = req_accept;
               if (c_delim) begin
                  push.first.tok_last = 1'b1;
                  push.push_second    = req_accept && bt_emit;
               end
            end
            MODE_ATOM_ESC: begin
               push.push_first = req_accept;
            end
            MODE_STR: begin
               push.push_first     = req_accept;
               push.first.tok_byte = req_byte;
               push.first.tok_last = (req_byte == CHAR_QUOTE);
            end
            MODE_STR_ESC: begin
               push.push_first     = req_accept;
               push.first.tok_byte = req_byte;
            end
            MODE_COMMENT: begin
               push.push_first = 1'b0;
            end
            default: begin
               push.push_first = req_accept && bt_emit;
               push.first      = bt_res;
            end
         endcase
      end
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else if (req_accept) begin
         mode_ff       <= mode_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // A byte is held exactly while an atom is open
   assert property (@(posedge clock) disable iff (reset)
      held_valid_ff == (mode_ff == MODE_ATOM || mode_ff == MODE_ATOM_ESC))
      else $error("held byte out of step with atom mode");

   // End of input returns the lexer to its idle state
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_END |=> mode_ff == MODE_IDLE && !held_valid_ff)
      else $error("lexer not idle after end of input");

   // An end code only appears on the end-of-input result
   assert property (@(posedge clock) disable iff (reset)
      push.push_first && push.first.end_status != END_NONE |-> req_kind == KIND_END)
      else $error("end code on a byte result");

   // A second result only follows a held atom byte closed by a delimiter
   assert property (@(posedge clock) disable iff (reset)
      push.push_second |-> push.push_first && push.first.tok_last && mode_ff == MODE_ATOM)
      else $error("second result without a closed atom");

endmodule

### rtl/lstok_result_queue.sv
// Result queue: takes up to two results per cycle from the lexer core and
// hands them out one per cycle while rsp_tready is high. Depends on lstok_pkg.
module lstok_result_queue #(
   parameter int unsigned DEPTH = lstok_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lstok_pkg::tok_push_type   push,
   output logic                      room_two,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output lstok_pkg::tok_result_type rsp_item
);
   import lstok_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   tok_result_type  slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_item   = slots_ff[rd_ptr_ff];
   assign room_two   = (count_ff <= CntW'(DEPTH - 2));
   assign wr_next    = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.push_first && push.push_second) begin
         wr_ptr_in = (wr_next == LastPtr) ? '0 : wr_next + 1'b1;
      end else if (push.push_first) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push.push_first) + CntW'(push.push_second)
                 - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store results
   always_ff @(posedge clock) begin
      if (push.push_first) begin
         slots_ff[wr_ptr_ff] <= push.first;
      end
      if (push.push_second) begin
         slots_ff[wr_next] <= push.second;
      end
   end

   // Fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(DEPTH))
      else $error("result queue overflow");

   // Results only arrive while two entries are free
   assert property (@(posedge clock) disable iff (reset) push.push_first |-> room_two)
      else $error("push into a queue without room");

   // Second result never comes alone
   assert property (@(posedge clock) disable iff (reset)
      push.push_second |-> push.push_first)
      else $error("second result without first");

endmodule

### rtl/lisp_source_tokenizer_unit.sv
// Top level of the Lisp source tokenizer: lexer core plus result queue.
// Depends on lstok_pkg, lstok_lexer_core and lstok_result_queue.
//
//  channel | ports      | tdata      | tuser                          | tlast
//  --------+------------+------------+--------------------------------+----------
//  request | req_*      | src_byte   | kind                           | -
//  result  | rsp_*      | tok_byte   | tok_valid, end_status[1:0]     | tok_last
//
// One request is taken per cycle; it is lexed in the same cycle and its
// zero, one or two results are written into the result queue at the edge.
// Results leave one per cycle, so a request that closes an atom with a
// delimiter token adds one extra result to the output; req_tready is low while
// fewer than two queue entries are free. Reset clears the lexer mode, the
// held atom byte and the queue. A stall on rsp_tready fills the queue,
// which then holds req_tready low.
module lisp_source_tokenizer_unit #(
   parameter int unsigned QueueDepth = lstok_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] src_byte
   input  logic [0:0] req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tok_byte
   output logic [2:0] rsp_tuser,   // [0] tok_valid, [2:1] end_status
   output logic       rsp_tlast    // tok_last
);
   import lstok_pkg::*;

   tok_push_type   push;
   tok_result_type rsp_item;
   logic           room_two;
   logic           req_accept;

   assign req_tready = room_two;
   assign req_accept = req_tvalid && req_tready;

   lstok_lexer_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_tuser[0]),
      .req_byte   (req_tdata),
      .push       (push)
   );

   lstok_result_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_two   (room_two),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Unpack the queue head onto the result channel
   assign rsp_tdata = rsp_item.tok_byte;
   assign rsp_tuser = {rsp_item.end_status, rsp_item.tok_valid};
   assign rsp_tlast = rsp_item.tok_last;

endmodule
